// ----- rtl/core/mtdi_pkg.sv -----
// mtdi_pkg: shared types, constants and helpers of the multitap delay block
// used by mtdi_ctl, mtdi_lane and multitap_delay_interp
// no dependencies
package mtdi_pkg;

    // store depth and channel count defaults
    localparam int unsigned DELAY_DEPTH_DEF = 131072;
    localparam int unsigned CHANNELS_DEF    = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_BASE_TARGET = 3'd0;
    localparam logic [2:0] CFG_FEEDBACK    = 3'd1;
    localparam logic [2:0] CFG_WET_MIX     = 3'd2;
    localparam logic [2:0] CFG_TAP_MULS    = 3'd3;
    localparam logic [2:0] CFG_TAP_GAINS   = 3'd4;

    // configuration reset values
    localparam logic [16:0] TARGET_RST   = 17'd14400;
    localparam logic [15:0] FEEDBACK_RST = 16'd19661;
    localparam logic [16:0] WET_MIX_RST  = 17'd22938;
    localparam logic [47:0] TAP_MULS_RST = 48'd141746930089984;
    localparam logic [63:0] TAP_GAIN_RST = 64'd9223750600063762432;

    // fixed point constants
    localparam logic [16:0] Q16_ONE  = 17'd65536;
    localparam logic [15:0] Q13_ONE  = 16'd8192;
    localparam logic [7:0]  SLEW_Q16 = 8'd98;

    localparam logic signed [63:0] S24_MAX = 64'sd8388607;
    localparam logic signed [63:0] S24_MIN = -64'sd8388608;

    // per-step strobes from the sequencer to the channel lanes
    typedef struct packed {
        logic start;
        logic rd;
        logic mult;
        logic tsum;
        logic gain;
        logic acc;
        logic first;
        logic mix0;
        logic mix1;
        logic fin;
    } t_lane_ctl;

    // saturate to a signed 24-bit sample
    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > S24_MAX) begin
            r = 24'sh7FFFFF;
        end else if (v < S24_MIN) begin
            r = -24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mtdi_ctl.sv -----
// mtdi_ctl: frame sequencer, base delay slew and tap read position unit
// shared by all channel lanes; depends on mtdi_pkg
module mtdi_ctl #(
    parameter int unsigned DELAY_DEPTH = mtdi_pkg::DELAY_DEPTH_DEF,
    parameter int unsigned AW          = $clog2(DELAY_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_out_busy,
    input  logic [16:0]          i_base_delay_target,
    input  logic [47:0]          i_tap_multipliers,
    input  logic [63:0]          i_tap_gains,
    output mtdi_pkg::t_lane_ctl  o_ctl,
    output logic [AW-1:0]        o_rd_addr0,
    output logic [AW-1:0]        o_rd_addr1,
    output logic                 o_rd_ok0,
    output logic                 o_rd_ok1,
    output logic [15:0]          o_frac,
    output logic [15:0]          o_gain,
    output logic [AW-1:0]        o_wr_addr,
    output logic                 o_load
);
    import mtdi_pkg::*;

    localparam int unsigned BW  = AW + 16;
    localparam int unsigned PW  = AW + 20;
    localparam int unsigned CW  = ((AW > 17) ? AW : 17) + 1;
    localparam int unsigned RST_SAMP =
        (int'(TARGET_RST) > DELAY_DEPTH - 1) ? DELAY_DEPTH - 1 : int'(TARGET_RST);
    localparam logic [BW-1:0] BASE_RST = BW'(RST_SAMP) << 16;
    localparam logic [PW-1:0] SPAN     = PW'(DELAY_DEPTH) << 16;
    localparam logic [CW-1:0] HI_SAMP  = CW'(DELAY_DEPTH - 2);
    localparam logic [AW-1:0] LAST     = AW'(DELAY_DEPTH - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SLEW = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_POS  = 4'd3;
    localparam logic [3:0] S_RED  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_MULT = 4'd6;
    localparam logic [3:0] S_TSUM = 4'd7;
    localparam logic [3:0] S_GAIN = 4'd8;
    localparam logic [3:0] S_ACC  = 4'd9;
    localparam logic [3:0] S_MIX0 = 4'd10;
    localparam logic [3:0] S_MIX1 = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0]      r_state, n_state;
    logic [1:0]      r_tap;
    logic [1:0]      r_k;
    logic [BW-1:0]   r_base;
    logic [BW+15:0]  r_prod;
    logic [PW-1:0]   r_pos;
    logic [AW-1:0]   r_wpos;
    logic            r_full;

    logic [CW-1:0]          tgt_samp;
    logic [BW-1:0]          tgt_q;
    logic signed [BW:0]     diff;
    logic signed [BW+8:0]   slew_prod;
    logic signed [BW+8:0]   slew_step;
    logic [15:0]            mul;
    logic [BW+2:0]          delay;
    logic [PW-1:0]          red_sub;
    logic [AW-1:0]          a0;
    logic [AW-1:0]          a1;
    logic                   accept;

    assign accept = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    // target clamp and slew step
    always_comb begin
        tgt_samp = CW'(i_base_delay_target);
        if (tgt_samp == '0) begin
            tgt_samp = CW'(1);
        end else if (tgt_samp > HI_SAMP) begin
            tgt_samp = HI_SAMP;
        end
        tgt_q     = {tgt_samp[AW-1:0], 16'b0};
        diff      = $signed({1'b0, tgt_q}) - $signed({1'b0, r_base});
        slew_prod = diff * $signed({1'b0, SLEW_Q16});
        slew_step = slew_prod >>> 16;
    end

    // per-tap multiplier and gain select
    always_comb begin
        case (r_tap)
            2'd0:    mul = Q13_ONE;
            2'd1:    mul = i_tap_multipliers[15:0];
            2'd2:    mul = i_tap_multipliers[31:16];
            default: mul = i_tap_multipliers[47:32];
        endcase
        case (r_tap)
            2'd0:    o_gain = i_tap_gains[15:0];
            2'd1:    o_gain = i_tap_gains[31:16];
            2'd2:    o_gain = i_tap_gains[47:32];
            default: o_gain = i_tap_gains[63:48];
        endcase
        delay = r_prod[BW+15:13];
        case (r_k)
            2'd3:    red_sub = SPAN << 3;
            2'd2:    red_sub = SPAN << 2;
            2'd1:    red_sub = SPAN << 1;
            default: red_sub = SPAN;
        endcase
    end

    // read addresses; entries past the fill point read as zero
    always_comb begin
        a0 = r_pos[AW+15:16];
        a1 = (a0 == LAST) ? '0 : a0 + AW'(1);
        o_rd_addr0 = a0;
        o_rd_addr1 = a1;
        o_rd_ok0   = r_full || (a0 < r_wpos);
        o_rd_ok1   = r_full || (a1 < r_wpos);
        o_frac     = r_pos[15:0];
        o_wr_addr  = r_wpos;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_SLEW;
            S_SLEW: n_state = S_MUL;
            S_MUL:  n_state = S_POS;
            S_POS:  n_state = S_RED;
            S_RED:  if (r_k == 2'd0) n_state = S_RD;
            S_RD:   n_state = S_MULT;
            S_MULT: n_state = S_TSUM;
            S_TSUM: n_state = S_GAIN;
            S_GAIN: n_state = S_ACC;
            S_ACC:  n_state = (r_tap == 2'd3) ? S_MIX0 : S_MUL;
            S_MIX0: n_state = S_MIX1;
            S_MIX1: n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (!i_out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // lane strobes
    always_comb begin
        o_ctl       = '0;
        o_ctl.start = accept;
        o_ctl.rd    = (r_state == S_RD);
        o_ctl.mult  = (r_state == S_MULT);
        o_ctl.tsum  = (r_state == S_TSUM);
        o_ctl.gain  = (r_state == S_GAIN);
        o_ctl.acc   = (r_state == S_ACC);
        o_ctl.first = (r_tap == 2'd0);
        o_ctl.mix0  = (r_state == S_MIX0);
        o_ctl.mix1  = (r_state == S_MIX1);
        o_ctl.fin   = (r_state == S_FIN);
        o_load      = (r_state == S_DONE) && !i_out_busy;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_k     <= '0;
            r_base  <= BASE_RST;
            r_wpos  <= '0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_SLEW: begin
                    r_base <= r_base + slew_step[BW-1:0];
                    r_tap  <= '0;
                end
                S_POS:  r_k <= 2'd3;
                S_RED:  r_k <= r_k - 2'd1;
                S_ACC:  r_tap <= r_tap + 2'd1;
                S_DONE: begin
                    if (!i_out_busy) begin
                        if (r_wpos == LAST) begin
                            r_wpos <= '0;
                            r_full <= 1'b1;
                        end else begin
                            r_wpos <= r_wpos + AW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // tap delay product and position reduction
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL: r_prod <= r_base * mul;
            S_POS: r_pos  <= PW'({r_wpos, 16'b0}) + (SPAN << 3) - PW'(delay);
            S_RED: if (r_pos >= red_sub) r_pos <= r_pos - red_sub;
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/mtdi_lane.sv -----
// mtdi_lane: one channel's delay store, tap interpolation, wet sum and mix
// depends on mtdi_pkg; driven step by step by mtdi_ctl
module mtdi_lane #(
    parameter int unsigned DELAY_DEPTH = mtdi_pkg::DELAY_DEPTH_DEF,
    parameter int unsigned AW          = $clog2(DELAY_DEPTH)
) (
    input  logic                 i_clk,
    input  mtdi_pkg::t_lane_ctl  i_ctl,
    input  logic signed [23:0]   i_x,
    input  logic [AW-1:0]        i_rd_addr0,
    input  logic [AW-1:0]        i_rd_addr1,
    input  logic                 i_rd_ok0,
    input  logic                 i_rd_ok1,
    input  logic [15:0]          i_frac,
    input  logic [15:0]          i_gain,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [16:0]          i_mix,
    input  logic [16:0]          i_dry,
    input  logic [15:0]          i_feedback,
    output logic signed [23:0]   o_y
);
    import mtdi_pkg::*;

    logic [23:0] r_mem [DELAY_DEPTH];

    logic signed [23:0] r_x;
    logic [23:0]        r_s0, r_s1;
    logic               r_ok0, r_ok1;
    logic [15:0]        r_f;
    logic signed [41:0] r_m0, r_m1;
    logic signed [23:0] r_tap, r_tap1;
    logic signed [40:0] r_gp;
    logic signed [42:0] r_wet;
    logic signed [41:0] r_pd;
    logic signed [39:0] r_plo, r_phi;
    logic signed [40:0] r_fb;
    logic signed [23:0] r_y;

    logic signed [23:0] s0, s1;
    logic signed [42:0] isum;
    logic signed [42:0] tap_w;
    logic signed [63:0] total;
    logic signed [63:0] total_sh;
    logic signed [40:0] fb_sh;
    logic signed [24:0] st_sum;
    logic signed [23:0] st_val;
    logic signed [23:0] y_val;

    always_comb begin
        s0       = r_ok0 ? $signed(r_s0) : 24'sd0;
        s1       = r_ok1 ? $signed(r_s1) : 24'sd0;
        isum     = 43'(r_m0) + 43'(r_m1);
        tap_w    = isum >>> 16;
        total    = (64'(r_pd) <<< 16) + 64'(r_plo) + (64'(r_phi) <<< 21);
        total_sh = total >>> 32;
        y_val    = sat24(total_sh);
        fb_sh    = r_fb >>> 16;
        st_sum   = 25'(r_x) + fb_sh[24:0];
        st_val   = sat24(64'(st_sum));
    end

    // delay store: two read ports, one write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_s0 <= r_mem[i_rd_addr0];
            r_s1 <= r_mem[i_rd_addr1];
        end
        if (i_ctl.fin) begin
            r_mem[i_wr_addr] <= st_val;
        end
    end

    // interpolation, gain, wet sum and mix
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= i_x;
            r_wet <= '0;
        end
        if (i_ctl.rd) begin
            r_ok0 <= i_rd_ok0;
            r_ok1 <= i_rd_ok1;
            r_f   <= i_frac;
        end
        if (i_ctl.mult) begin
            r_m0 <= s0 * $signed({1'b0, Q16_ONE - {1'b0, r_f}});
            r_m1 <= s1 * $signed({2'b0, r_f});
        end
        if (i_ctl.tsum) begin
            r_tap <= tap_w[23:0];
        end
        if (i_ctl.gain) begin
            r_gp <= r_tap * $signed({1'b0, i_gain});
            if (i_ctl.first) r_tap1 <= r_tap;
        end
        if (i_ctl.acc) begin
            r_wet <= r_wet + 43'(r_gp);
        end
        if (i_ctl.mix0) begin
            r_pd  <= r_x * $signed({1'b0, i_dry});
            r_plo <= $signed({1'b0, i_mix}) * $signed({1'b0, r_wet[20:0]});
        end
        if (i_ctl.mix1) begin
            r_phi <= $signed({1'b0, i_mix}) * $signed(r_wet[42:21]);
            r_fb  <= r_tap1 * $signed({1'b0, i_feedback});
        end
        if (i_ctl.fin) begin
            r_y <= y_val;
        end
    end

    assign o_y = r_y;

endmodule

// ----- rtl/core/multitap_delay_interp.sv -----
// Multitap fractional delay with feedback. Each stereo frame runs through
// a slew step, then the four taps, which go one after another through the
// shared read position unit (product, four reduction steps) and each
// lane's multiplier chain, then mixing, store write and output load.
// Channels run as parallel lanes, each with its own single-write, dual-read
// delay store. Store entries not yet written since reset read as zero
// through a fill pointer, so no clearing pass is needed. o_stall is high
// while a frame is in work; a finished frame waits in the output register.
// depends on mtdi_pkg, mtdi_ctl, mtdi_lane
module multitap_delay_interp #(
    parameter int unsigned DELAY_DEPTH = mtdi_pkg::DELAY_DEPTH_DEF,
    parameter int unsigned CHANNELS    = mtdi_pkg::CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_in_left,
    input  logic signed [23:0] i_in_right,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_out_left,
    output logic signed [23:0] o_out_right,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);
    import mtdi_pkg::*;

    localparam int unsigned AW = $clog2(DELAY_DEPTH);

    logic [16:0] r_base_delay_target;
    logic [15:0] r_feedback_gain;
    logic [16:0] r_wet_mix;
    logic [47:0] r_tap_multipliers;
    logic [63:0] r_tap_gains;

    logic               r_out_valid;
    logic signed [23:0] r_out_left, r_out_right;

    t_lane_ctl      ctl;
    logic [AW-1:0]  rd_addr0, rd_addr1, wr_addr;
    logic           rd_ok0, rd_ok1, load, out_busy;
    logic [15:0]    frac, gain;
    logic [16:0]    mix, dry;
    logic signed [23:0] y_left, y_right;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay_target <= TARGET_RST;
            r_feedback_gain     <= FEEDBACK_RST;
            r_wet_mix           <= WET_MIX_RST;
            r_tap_multipliers   <= TAP_MULS_RST;
            r_tap_gains         <= TAP_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_TARGET: r_base_delay_target <= i_cfg_data[16:0];
                CFG_FEEDBACK:    r_feedback_gain     <= i_cfg_data[15:0];
                CFG_WET_MIX:     r_wet_mix           <= i_cfg_data[16:0];
                CFG_TAP_MULS:    r_tap_multipliers   <= i_cfg_data[47:0];
                CFG_TAP_GAINS:   r_tap_gains         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // mix limited to one, dry is the rest
    assign mix = (r_wet_mix > Q16_ONE) ? Q16_ONE : r_wet_mix;
    assign dry = Q16_ONE - mix;

    assign out_busy = r_out_valid && i_stall;

    mtdi_ctl #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .AW          (AW)
    ) u_ctl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_out_busy          (out_busy),
        .i_base_delay_target (r_base_delay_target),
        .i_tap_multipliers   (r_tap_multipliers),
        .i_tap_gains         (r_tap_gains),
        .o_ctl               (ctl),
        .o_rd_addr0          (rd_addr0),
        .o_rd_addr1          (rd_addr1),
        .o_rd_ok0            (rd_ok0),
        .o_rd_ok1            (rd_ok1),
        .o_frac              (frac),
        .o_gain              (gain),
        .o_wr_addr           (wr_addr),
        .o_load              (load)
    );

    // left lane, always present
    mtdi_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .AW          (AW)
    ) u_lane_l (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_x        (i_in_left),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (rd_addr1),
        .i_rd_ok0   (rd_ok0),
        .i_rd_ok1   (rd_ok1),
        .i_frac     (frac),
        .i_gain     (gain),
        .i_wr_addr  (wr_addr),
        .i_mix      (mix),
        .i_dry      (dry),
        .i_feedback (r_feedback_gain),
        .o_y        (y_left)
    );

    // right lane only for stereo
    if (CHANNELS > 1) begin : g_right
        mtdi_lane #(
            .DELAY_DEPTH (DELAY_DEPTH),
            .AW          (AW)
        ) u_lane_r (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_x        (i_in_right),
            .i_rd_addr0 (rd_addr0),
            .i_rd_addr1 (rd_addr1),
            .i_rd_ok0   (rd_ok0),
            .i_rd_ok1   (rd_ok1),
            .i_frac     (frac),
            .i_gain     (gain),
            .i_wr_addr  (wr_addr),
            .i_mix      (mix),
            .i_dry      (dry),
            .i_feedback (r_feedback_gain),
            .o_y        (y_right)
        );
    end else begin : g_mono
        assign y_right = 24'sd0;
    end

    // merge lanes into the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_left  <= y_left;
            r_out_right <= y_right;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_left  = r_out_left;
    assign o_out_right = r_out_right;

endmodule

// ----- sim/tb.sv -----
// tb: self-checking testbench for multitap_delay_interp, with a scoreboard class
// that predicts each stereo frame and checks the mixed output beats in order
// depends on mtdi_pkg and multitap_delay_interp
`timescale 1ns / 100ps

module tb;
    import mtdi_pkg::*;

    localparam int unsigned DEPTH     = DELAY_DEPTH_DEF;
    localparam longint     SPAN       = longint'(DEPTH) * 65536;
    localparam int         WDOG_LIMIT = 20000;
    localparam int         DRAIN_CYC  = 60;
    localparam logic [2:0] CFG_SPARE5 = 3'd5;
    localparam logic [2:0] CFG_SPARE7 = 3'd7;

    // idling modes
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } t_frame;

    // delay line predictor and expected-frame store
    class delay_scoreboard;
        int       store [2][DEPTH];
        int       wpos;
        longint   base_q16;
        longint   target;
        longint   fb_gain;
        longint   mix;
        bit [47:0] muls;
        bit [63:0] gains;
        t_frame   expected_q [$];
        int       errors;

        function new();
            foreach (store[c, i]) store[c][i] = 0;
            wpos     = 0;
            target   = TARGET_RST;
            fb_gain  = FEEDBACK_RST;
            mix      = WET_MIX_RST;
            muls     = TAP_MULS_RST;
            gains    = TAP_GAIN_RST;
            base_q16 = longint'(TARGET_RST) <<< 16;
            errors   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                CFG_BASE_TARGET: target  = longint'(d[16:0]);
                CFG_FEEDBACK:    fb_gain = longint'(d[15:0]);
                CFG_WET_MIX:     mix     = longint'(d[16:0]);
                CFG_TAP_MULS:    muls    = d[47:0];
                CFG_TAP_GAINS:   gains   = d;
                default: ;
            endcase
        endfunction

        function longint sat(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        // one frame through the delay line, expected beat queued
        function void note_frame(logic signed [23:0] xl, logic signed [23:0] xr);
            longint tgt, m, dry, x, wet, tap1, mul, gain, dly, pos, r, f, v, y;
            int     i0, i1;
            t_frame e;
            tgt = target;
            if (tgt < 1) tgt = 1;
            if (tgt > DEPTH - 2) tgt = DEPTH - 2;
            tgt = tgt <<< 16;
            m   = (mix > 65536) ? 65536 : mix;
            dry = 65536 - m;
            base_q16 += ((tgt - base_q16) * 98) >>> 16;
            for (int ch = 0; ch < 2; ch++) begin
                x    = (ch == 0) ? longint'(xl) : longint'(xr);
                wet  = 0;
                tap1 = 0;
                for (int t = 0; t < 4; t++) begin
                    mul  = (t == 0) ? 8192 : longint'((muls >> (16 * (t - 1))) & 48'hFFFF);
                    gain = longint'((gains >> (16 * t)) & 64'hFFFF);
                    dly  = (base_q16 * mul) >>> 13;
                    pos  = longint'(wpos) * 65536 - dly;
                    r    = pos & (SPAN - 1);
                    i0   = int'(r >>> 16);
                    i1   = (i0 + 1) % DEPTH;
                    f    = r & 64'hFFFF;
                    v    = (longint'(store[ch][i0]) * (65536 - f)
                            + longint'(store[ch][i1]) * f) >>> 16;
                    if (t == 0) tap1 = v;
                    wet += gain * v;
                end
                y = sat((dry * x * 65536 + m * wet) >>> 32);
                if (ch == 0) e.left = y[23:0];
                else         e.right = y[23:0];
                store[ch][wpos] = int'(sat(x + ((fb_gain * tap1) >>> 16)));
            end
            wpos = (wpos + 1) % DEPTH;
            expected_q.push_back(e);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_frame(logic signed [23:0] ol, logic signed [23:0] orr);
            t_frame e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat %0d/%0d", ol, orr));
            end else begin
                e = expected_q.pop_front();
                if (ol !== e.left)
                    report($sformatf("out_left %0d, expected %0d", ol, e.left));
                if (orr !== e.right)
                    report($sformatf("out_right %0d, expected %0d", orr, e.right));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [23:0] i_in_left = '0;
    logic signed [23:0] i_in_right = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [23:0] o_out_left;
    logic signed [23:0] o_out_right;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [63:0]        i_cfg_data = '0;

    delay_scoreboard sb = new();
    t_idle           idle_mode = IDLE_NONE;
    int              quiet_cycles = 0;

    multitap_delay_interp DUT (.*);

    always #5 i_clk = ~i_clk;

    // output side: check accepted beats, random stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_frame(o_out_left, o_out_right);
        if ((idle_mode == IDLE_RECV && $urandom_range(99) < 85) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 25))
            i_stall <= 1'b1;
        else
            i_stall <= 1'b0;
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task cfg_write(input logic [2:0] idx, input logic [63:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    // one input beat, with optional idle cycles ahead of it
    task send_frame(input logic signed [23:0] l, input logic signed [23:0] r);
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 85) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 25)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_left  <= l;
        i_in_right <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_frame(l, r);
    endtask

    task wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function logic signed [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
            default: return 24'($urandom);
        endcase
    endfunction

    function logic [15:0] rand_mul();
        case ($urandom_range(7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    // garbage above the register width checks masking
    function logic [63:0] with_junk(input logic [63:0] v, input int w);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        return (junk << w) | v;
    endfunction

    initial begin
        logic [16:0] tgt, mx;
        logic [15:0] fb;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sample extremes at reset settings
        send_frame(24'sh7FFFFF, -24'sh800000);
        send_frame(-24'sh800000, 24'sh7FFFFF);
        send_frame(24'sd0, 24'sd0);
        send_frame(24'sd1, -24'sd1);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        send_frame(-24'sh800000, -24'sh800000);
        wait_drained();

        // directed: zero multipliers read oldest entry, feedback of 0.9, mix over one
        cfg_write(CFG_TAP_MULS, 64'h0);
        cfg_write(CFG_FEEDBACK, 64'd58982);
        cfg_write(CFG_WET_MIX, 64'd131071);
        cfg_write(CFG_TAP_GAINS, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_BASE_TARGET, 64'd0);
        cfg_write(CFG_SPARE7, 64'hDEAD_BEEF);
        for (int i = 0; i < 19; i++) send_frame(rand_sample(), rand_sample());
        wait_drained();

        // random phases over settings and idling modes
        for (int p = 1; p <= 8; p++) begin
            case (p)
                1: begin tgt = 17'd1;      fb = 16'd58982; mx = 17'd65536;  end
                2: begin tgt = 17'd131071; fb = 16'd0;     mx = 17'd0;      end
                3: begin tgt = 17'd0;      fb = 16'd30000; mx = 17'd131071; end
                4: begin tgt = 17'd131070; fb = 16'd58982; mx = 17'd32768;  end
                default: begin
                    tgt = 17'($urandom_range(1, 200));
                    fb  = 16'($urandom_range(0, 58982));
                    mx  = 17'($urandom_range(0, 65536));
                end
            endcase
            cfg_write(CFG_BASE_TARGET, with_junk(64'(tgt), 17));
            cfg_write(CFG_FEEDBACK, with_junk(64'(fb), 16));
            cfg_write(CFG_WET_MIX, with_junk(64'(mx), 17));
            if (p == 2)
                cfg_write(CFG_TAP_MULS,
                          with_junk(64'({$urandom, $urandom}) & 64'hFFFF_FFFF_FFFF, 48));
            else
                cfg_write(CFG_TAP_MULS, with_junk(64'({rand_mul(), rand_mul(), rand_mul()}), 48));
            cfg_write(CFG_TAP_GAINS, {$urandom, $urandom});
            cfg_write(CFG_SPARE5, {$urandom, $urandom});
            idle_mode = t_idle'(p % 4);
            for (int i = 0; i < 130; i++) send_frame(rand_sample(), rand_sample());
            wait_drained();
            idle_mode = IDLE_NONE;
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mtdi_pkg.sv
rtl/core/mtdi_ctl.sv
rtl/core/mtdi_lane.sv
rtl/core/multitap_delay_interp.sv
sim/tb.sv
